>>> rtl/ccns_pkg.sv
// Package for the center crop nearest scaler: widths, register codes, request types.
package ccns_pkg;

   localparam int REG_W   = 13;
   localparam int COORD_W = 12;
   localparam int ADDR_W  = 24;
   localparam int REG_MAX = (2 ** REG_W) - 1;
   localparam int CSR_INDEX_W = 2;

   localparam int DEFAULT_MAX_DIMENSION = 4096;

   localparam logic [REG_W-1:0] RESET_SOURCE_WIDTH  = REG_W'(1288);
   localparam logic [REG_W-1:0] RESET_SOURCE_HEIGHT = REG_W'(728);
   localparam logic [REG_W-1:0] RESET_TARGET_WIDTH  = REG_W'(480);
   localparam logic [REG_W-1:0] RESET_TARGET_HEIGHT = REG_W'(696);

   localparam logic [CSR_INDEX_W-1:0] REG_SOURCE_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_SOURCE_HEIGHT = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] REG_TARGET_WIDTH  = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] REG_TARGET_HEIGHT = CSR_INDEX_W'(3);

   typedef struct packed {
      logic [COORD_W-1:0] target_x;
      logic [COORD_W-1:0] target_y;
   } ccns_req_type;

   typedef struct packed {
      logic [COORD_W-1:0] source_x;
      logic [COORD_W-1:0] source_y;
      logic [ADDR_W-1:0]  source_address;
      logic [ADDR_W-1:0]  target_address;
      logic               coordinate_valid;
   } ccns_rsp_type;

endpackage

>>> rtl/center_crop_nearest_scaler.sv
// Top level of the center crop nearest scaler: source pixel address generator.
//
// A request carries a target pixel (target_x, target_y). Each request gives one
// response with the source pixel that fills it under a centered, aspect-keeping
// crop and nearest-neighbor scaling, plus linear source and target addresses.
// Coordinates outside the target frame give coordinate_valid = 0 and zeros.
// Four dimension registers are written through the csr_ port; the user must
// write them only while idle, as the block does not enforce it. Throughput: one
// request per clock while rsp_stall does not hold the pipeline. The crop divider
// row and the two scale divider rows each give an EW-bit quotient, one bit per
// cell, EW being the effective dimension width (13 at MAX_DIMENSION = 4096).
// A request arriving while the pipeline is held lands in a one-entry skid buffer.
// When rsp_stall is high with a response waiting, the pipeline holds; one more
// request is still taken into the skid buffer, then req_stall rises.
// Synchronous reset empties the pipeline and skid buffer and loads the
// registers with 1288 x 728 source and 480 x 696 target.
module center_crop_nearest_scaler
   import ccns_pkg::*;
#(
   parameter int MAX_DIMENSION = DEFAULT_MAX_DIMENSION
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ccns_req_type           req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ccns_rsp_type           rsp_payload,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [REG_W-1:0]       csr_data
);

   localparam int CLAMP  = (MAX_DIMENSION > REG_MAX) ? REG_MAX : MAX_DIMENSION;
   localparam int EW     = $clog2(CLAMP + 1);
   localparam int PW     = 2 * EW;
   localparam int TW     = PW + 1;
   localparam int CMP_W  = (COORD_W > EW) ? COORD_W : EW;
   localparam int DEPTH  = 2 * EW + 7;
   localparam int CROP_SIDE_W = 6 * EW + 2 + ADDR_W;
   localparam int Y_SIDE_W    = 2 * EW + 1 + ADDR_W;

   function automatic logic [EW-1:0] eff_dim(input logic [REG_W-1:0] v);
      logic [REG_W-1:0] c;
      c = v;
      if (v == '0) begin
         c = REG_W'(1);
      end else if (v > REG_W'(CLAMP)) begin
         c = REG_W'(CLAMP);
      end
      return EW'(c);
   endfunction

   // configuration registers
   logic [REG_W-1:0] src_w_ff, src_h_ff, tgt_w_ff, tgt_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= RESET_SOURCE_WIDTH;
         src_h_ff <= RESET_SOURCE_HEIGHT;
         tgt_w_ff <= RESET_TARGET_WIDTH;
         tgt_h_ff <= RESET_TARGET_HEIGHT;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_SOURCE_WIDTH:  src_w_ff <= csr_data;
            REG_SOURCE_HEIGHT: src_h_ff <= csr_data;
            REG_TARGET_WIDTH:  tgt_w_ff <= csr_data;
            REG_TARGET_HEIGHT: tgt_h_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // control: skid buffer and valid line
   logic               advance;
   logic               skid_full_ff, skid_full_in;
   ccns_req_type       skid_ff;
   logic [DEPTH-1:0]   valid_ff, valid_in;
   logic               entry_valid;
   ccns_req_type       entry_req;

   assign advance     = !valid_ff[DEPTH-1] || !rsp_stall;
   assign req_stall   = skid_full_ff;
   assign entry_valid = skid_full_ff || req_valid;
   assign entry_req   = skid_full_ff ? skid_ff : req_payload;

   always_comb begin
      skid_full_in = skid_full_ff;
      valid_in     = valid_ff;
      if (advance) begin
         skid_full_in = 1'b0;
         valid_in     = {valid_ff[DEPTH-2:0], entry_valid};
      end else if (req_valid) begin
         skid_full_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_full_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         skid_full_ff <= skid_full_in;
         valid_ff     <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_full_ff && !advance && req_valid) begin
         skid_ff <= req_payload;
      end
   end

   // entry stage
   logic [EW-1:0] ent_sw, ent_sh, ent_tw, ent_th;
   logic          ent_in;

   always_comb begin
      ent_sw = eff_dim(src_w_ff);
      ent_sh = eff_dim(src_h_ff);
      ent_tw = eff_dim(tgt_w_ff);
      ent_th = eff_dim(tgt_h_ff);
      ent_in = (CMP_W'(entry_req.target_x) < CMP_W'(ent_tw))
            && (CMP_W'(entry_req.target_y) < CMP_W'(ent_th));
   end

   logic [EW-1:0] a_sw_ff, a_sh_ff, a_tw_ff, a_th_ff, a_x_ff, a_y_ff;
   logic          a_in_ff;
   logic [EW-1:0] b_sw_ff, b_sh_ff, b_tw_ff, b_th_ff, b_x_ff, b_y_ff;
   logic          b_in_ff;
   logic [PW-1:0] b_pw_ff, b_pt_ff, b_tmul_ff;
   logic [PW-1:0] c_num_ff;
   logic [EW-1:0] c_div_ff;
   logic [CROP_SIDE_W-1:0] c_side_ff;
   logic          c_wider;
   logic [TW-1:0] c_taddr;

   assign c_wider = b_pw_ff > b_pt_ff;
   assign c_taddr = TW'(b_tmul_ff) + TW'(b_x_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         a_sw_ff <= ent_sw;
         a_sh_ff <= ent_sh;
         a_tw_ff <= ent_tw;
         a_th_ff <= ent_th;
         a_x_ff  <= ent_in ? EW'(entry_req.target_x) : '0;
         a_y_ff  <= ent_in ? EW'(entry_req.target_y) : '0;
         a_in_ff <= ent_in;

         b_sw_ff   <= a_sw_ff;
         b_sh_ff   <= a_sh_ff;
         b_tw_ff   <= a_tw_ff;
         b_th_ff   <= a_th_ff;
         b_x_ff    <= a_x_ff;
         b_y_ff    <= a_y_ff;
         b_in_ff   <= a_in_ff;
         b_pw_ff   <= PW'(a_sw_ff) * PW'(a_th_ff);
         b_pt_ff   <= PW'(a_tw_ff) * PW'(a_sh_ff);
         b_tmul_ff <= PW'(a_y_ff) * PW'(a_tw_ff);

         c_num_ff  <= c_wider ? b_pt_ff : b_pw_ff;
         c_div_ff  <= c_wider ? b_th_ff : b_tw_ff;
         c_side_ff <= {b_sw_ff, b_sh_ff, b_tw_ff, b_th_ff, b_x_ff, b_y_ff,
                       b_in_ff, c_wider, ADDR_W'(c_taddr)};
      end
   end

   // crop size divider row
   logic [EW-1:0]          crop_q;
   logic [CROP_SIDE_W-1:0] crop_side;
   logic [EW-1:0]          k_sw, k_sh, k_tw, k_th, k_x, k_y;
   logic                   k_in, k_wider;
   logic [ADDR_W-1:0]      k_taddr;

   ccns_div_chain #(
      .W      (EW),
      .SIDE_W (CROP_SIDE_W)
   ) u_crop_div (
      .clock    (clock),
      .enable   (advance),
      .num_high (c_num_ff[PW-1:EW]),
      .num_low  (c_num_ff[EW-1:0]),
      .divisor  (c_div_ff),
      .side_in  (c_side_ff),
      .quotient (crop_q),
      .side_out (crop_side)
   );

   assign {k_sw, k_sh, k_tw, k_th, k_x, k_y, k_in, k_wider, k_taddr} = crop_side;

   logic [EW-1:0]     d_cw_ff, d_ch_ff, d_xoff_ff, d_yoff_ff;
   logic [EW-1:0]     d_x_ff, d_y_ff, d_tw_ff, d_th_ff, d_sw_ff;
   logic              d_in_ff;
   logic [ADDR_W-1:0] d_taddr_ff;
   logic [EW-1:0]     k_xgap, k_ygap;

   assign k_xgap = k_sw - crop_q;
   assign k_ygap = k_sh - crop_q;

   logic [PW-1:0]     e_mx_ff, e_my_ff;
   logic [EW-1:0]     e_tw_ff, e_th_ff, e_xoff_ff, e_yoff_ff, e_sw_ff;
   logic              e_in_ff;
   logic [ADDR_W-1:0] e_taddr_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         d_cw_ff    <= k_wider ? crop_q : k_sw;
         d_ch_ff    <= k_wider ? k_sh : crop_q;
         d_xoff_ff  <= k_wider ? (k_xgap >> 1) : '0;
         d_yoff_ff  <= k_wider ? '0 : (k_ygap >> 1);
         d_x_ff     <= k_x;
         d_y_ff     <= k_y;
         d_tw_ff    <= k_tw;
         d_th_ff    <= k_th;
         d_sw_ff    <= k_sw;
         d_in_ff    <= k_in;
         d_taddr_ff <= k_taddr;

         e_mx_ff    <= PW'(d_x_ff) * PW'(d_cw_ff);
         e_my_ff    <= PW'(d_y_ff) * PW'(d_ch_ff);
         e_tw_ff    <= d_tw_ff;
         e_th_ff    <= d_th_ff;
         e_xoff_ff  <= d_xoff_ff;
         e_yoff_ff  <= d_yoff_ff;
         e_sw_ff    <= d_sw_ff;
         e_in_ff    <= d_in_ff;
         e_taddr_ff <= d_taddr_ff;
      end
   end

   // scale divider rows
   logic [EW-1:0]       qx, qy, x_off;
   logic [Y_SIDE_W-1:0] y_side;
   logic [EW-1:0]       m_yoff, m_sw;
   logic                m_in;
   logic [ADDR_W-1:0]   m_taddr;

   ccns_div_chain #(
      .W      (EW),
      .SIDE_W (EW)
   ) u_xdiv (
      .clock    (clock),
      .enable   (advance),
      .num_high (e_mx_ff[PW-1:EW]),
      .num_low  (e_mx_ff[EW-1:0]),
      .divisor  (e_tw_ff),
      .side_in  (e_xoff_ff),
      .quotient (qx),
      .side_out (x_off)
   );

   ccns_div_chain #(
      .W      (EW),
      .SIDE_W (Y_SIDE_W)
   ) u_ydiv (
      .clock    (clock),
      .enable   (advance),
      .num_high (e_my_ff[PW-1:EW]),
      .num_low  (e_my_ff[EW-1:0]),
      .divisor  (e_th_ff),
      .side_in  ({e_yoff_ff, e_sw_ff, e_in_ff, e_taddr_ff}),
      .quotient (qy),
      .side_out (y_side)
   );

   assign {m_yoff, m_sw, m_in, m_taddr} = y_side;

   logic [EW-1:0]     f_sx_ff, f_sy_ff, f_sw_ff;
   logic              f_in_ff;
   logic [ADDR_W-1:0] f_taddr_ff;
   logic [TW-1:0]     g_saddr;
   ccns_rsp_type      rsp_ff, rsp_in;

   assign g_saddr = TW'(PW'(f_sy_ff) * PW'(f_sw_ff)) + TW'(f_sx_ff);

   always_comb begin
      rsp_in = '0;
      if (f_in_ff) begin
         rsp_in.source_x         = COORD_W'(f_sx_ff);
         rsp_in.source_y         = COORD_W'(f_sy_ff);
         rsp_in.source_address   = ADDR_W'(g_saddr);
         rsp_in.target_address   = f_taddr_ff;
         rsp_in.coordinate_valid = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f_sx_ff    <= x_off + qx;
         f_sy_ff    <= m_yoff + qy;
         f_sw_ff    <= m_sw;
         f_in_ff    <= m_in;
         f_taddr_ff <= m_taddr;
         rsp_ff     <= rsp_in;
      end
   end

   assign rsp_valid   = valid_ff[DEPTH-1];
   assign rsp_payload = rsp_ff;

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.coordinate_valid |->
         rsp_payload.source_x == '0 && rsp_payload.source_y == '0
         && rsp_payload.source_address == '0 && rsp_payload.target_address == '0)
      else $error("out-of-frame response carries nonzero fields");

   a_skid_load: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !advance |=> skid_full_ff)
      else $error("request taken while held was not parked in skid buffer");

   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      skid_full_ff && advance |=> !skid_full_ff)
      else $error("skid buffer did not drain on pipeline advance");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(valid_ff))
      else $error("valid line moved while pipeline held");

endmodule

>>> rtl/ccns_div_cell.sv
// One restoring-division cell: settles one quotient bit per request and passes it on.
module ccns_div_cell #(
   parameter int W      = 13,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              enable,
   input  logic [W-1:0]      up_rem,
   input  logic [W-1:0]      up_num,
   input  logic [W-1:0]      up_div,
   input  logic [SIDE_W-1:0] up_side,
   output logic [W-1:0]      dn_rem,
   output logic [W-1:0]      dn_num,
   output logic [W-1:0]      dn_div,
   output logic [SIDE_W-1:0] dn_side
);

   logic [W-1:0]      rem_ff, rem_in;
   logic [W-1:0]      num_ff, num_in;
   logic [W-1:0]      div_ff;
   logic [SIDE_W-1:0] side_ff;
   logic [W:0]        shifted;
   logic [W:0]        diff;
   logic              fits;

   // num holds the unused dividend bits on top and the quotient bits below
   always_comb begin
      shifted = {up_rem, up_num[W-1]};
      diff    = shifted - {1'b0, up_div};
      fits    = shifted >= {1'b0, up_div};
      rem_in  = fits ? diff[W-1:0] : shifted[W-1:0];
      num_in  = {up_num[W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff  <= rem_in;
         num_ff  <= num_in;
         div_ff  <= up_div;
         side_ff <= up_side;
      end
   end

   assign dn_rem  = rem_ff;
   assign dn_num  = num_ff;
   assign dn_div  = div_ff;
   assign dn_side = side_ff;

endmodule

>>> rtl/ccns_div_chain.sv
// Row of division cells: a pipelined divider giving a W-bit quotient per request.
module ccns_div_chain #(
   parameter int W      = 13,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              enable,
   input  logic [W-1:0]      num_high,
   input  logic [W-1:0]      num_low,
   input  logic [W-1:0]      divisor,
   input  logic [SIDE_W-1:0] side_in,
   output logic [W-1:0]      quotient,
   output logic [SIDE_W-1:0] side_out
);

   logic [W-1:0]      rem  [0:W];
   logic [W-1:0]      num  [0:W];
   logic [W-1:0]      dv   [0:W];
   logic [SIDE_W-1:0] side [0:W];

   assign rem[0]  = num_high;
   assign num[0]  = num_low;
   assign dv[0]   = divisor;
   assign side[0] = side_in;

   for (genvar i = 0; i < W; i++) begin : g_cell
      ccns_div_cell #(
         .W      (W),
         .SIDE_W (SIDE_W)
      ) u_cell (
         .clock   (clock),
         .enable  (enable),
         .up_rem  (rem[i]),
         .up_num  (num[i]),
         .up_div  (dv[i]),
         .up_side (side[i]),
         .dn_rem  (rem[i+1]),
         .dn_num  (num[i+1]),
         .dn_div  (dv[i+1]),
         .dn_side (side[i+1])
      );
   end

   assign quotient = num[W];
   assign side_out = side[W];

endmodule
